// ----- rtl/atcp_pkg.sv -----
// shared types, character codes and calendar constants for the time-code line parser
package atcp_pkg;

    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_COLON = 8'd58;

    localparam logic [13:0] YEAR_MAX       = 14'd9999;
    localparam logic [9:0]  DOY_MAX        = 10'd999;
    localparam logic [6:0]  TIME_MAX       = 7'd99;
    localparam logic [3:0]  TOKEN_MAX      = 4'd15;
    localparam logic [4:0]  YEAR_MAX_MOD25 = 5'd24;

    localparam logic [3:0] TOK_YEAR = 4'd0;
    localparam logic [3:0] TOK_DOY  = 4'd1;
    localparam logic [3:0] TOK_TIME = 4'd2;
    localparam logic [3:0] TOK_ZONE = 4'd3;

    // last day-of-year of each month in a common year
    localparam logic [8:0] MONTH_END [12] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    typedef struct packed {
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic        format_ok;
        logic [3:0]  token_total;
        logic [13:0] year_value;
        logic [9:0]  day_of_year;
        logic [3:0]  month_number;
        logic [4:0]  day_of_month;
        logic [6:0]  hour_value;
        logic [6:0]  minute_value;
        logic [6:0]  second_value;
        logic        zone_present;
        logic [31:0] zone_text;
    } result_t;

    // parser state seen by the result logic
    typedef struct packed {
        logic [3:0]  token_position;
        logic        line_nonempty;
        logic [13:0] year;
        logic [4:0]  year_mod25;
        logic [9:0]  doy;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [31:0] zone_bytes;
    } line_state_t;

    // acc * 10 + d, clipped at maxv
    function automatic logic [13:0] dec_push(logic [13:0] acc, logic [3:0] d,
                                             logic [13:0] maxv);
        logic [17:0] v;
        v = {4'd0, acc} * 18'd10 + {14'd0, d};
        return (v > {4'd0, maxv}) ? maxv : v[13:0];
    endfunction

    // v mod 25 for v below 250, by reciprocal multiply
    function automatic logic [4:0] mod25(logic [7:0] v);
        logic [13:0] p;
        logic [7:0]  r;
        p = {6'd0, v} * 14'd41;
        r = v - {4'd0, p[13:10]} * 8'd25;
        return r[4:0];
    endfunction

endpackage

// ----- rtl/atcp_stream_if.sv -----
// valid/ready channel carrying one item per handshake
interface atcp_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/atcp_parse.sv -----
// per-character token and field accumulation state of one line
module atcp_parse import atcp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  char_code,
    output line_state_t state
);

    logic [3:0]  token_position_reg, token_position_next;
    logic        inside_token_reg, inside_token_next;
    logic        line_nonempty_reg, line_nonempty_next;
    logic [13:0] year_reg, year_next;
    logic [4:0]  year_mod_reg, year_mod_next;
    logic [9:0]  doy_reg, doy_next;
    logic [6:0]  time_reg [3];
    logic [6:0]  time_next [3];
    logic [1:0]  part_reg, part_next;
    logic [2:0]  stopped_reg, stopped_next;
    logic        has_digit_reg, has_digit_next;
    logic [31:0] zone_reg, zone_next;
    logic [2:0]  zone_count_reg, zone_count_next;

    logic        is_digit;
    logic [7:0]  char_diff;
    logic [3:0]  digit;
    logic [3:0]  tok_pos;
    logic [3:0]  tok;
    logic [17:0] year_wide;
    logic [13:0] time_pushed;

    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign char_diff = char_code - CHAR_ZERO;
    assign digit     = char_diff[3:0];
    assign year_wide = {4'd0, year_reg} * 18'd10 + {14'd0, digit};
    assign time_pushed = dec_push({7'd0, time_reg[part_reg]}, digit, {7'd0, TIME_MAX});

    always_comb
    begin
        token_position_next = token_position_reg;
        inside_token_next   = inside_token_reg;
        line_nonempty_next  = line_nonempty_reg;
        year_next           = year_reg;
        year_mod_next       = year_mod_reg;
        doy_next            = doy_reg;
        time_next           = time_reg;
        part_next           = part_reg;
        stopped_next        = stopped_reg;
        has_digit_next      = has_digit_reg;
        zone_next           = zone_reg;
        zone_count_next     = zone_count_reg;

        tok_pos = token_position_reg;
        if (!inside_token_reg && token_position_reg < TOKEN_MAX)
        begin
            tok_pos = token_position_reg + 4'd1;
        end
        tok = tok_pos - 4'd1;

        if (step && char_code == CHAR_LF)
        begin
            token_position_next = '0;
            inside_token_next   = 1'b0;
            line_nonempty_next  = 1'b0;
            year_next           = '0;
            year_mod_next       = '0;
            doy_next            = '0;
            time_next           = '{3{7'd0}};
            part_next           = '0;
            stopped_next        = '0;
            has_digit_next      = 1'b0;
            zone_next           = '0;
            zone_count_next     = '0;
        end
        else if (step && char_code != CHAR_CR)
        begin
            line_nonempty_next = 1'b1;
            if (char_code == CHAR_SPACE || char_code == CHAR_TAB)
            begin
                inside_token_next = 1'b0;
            end
            else
            begin
                inside_token_next   = 1'b1;
                token_position_next = tok_pos;
                case (tok)
                    TOK_YEAR:
                    begin
                        if (!stopped_reg[0])
                        begin
                            if (is_digit)
                            begin
                                year_next = dec_push(year_reg, digit, YEAR_MAX);
                                // track year mod 25 for the century leap rules
                                if (year_wide > {4'd0, YEAR_MAX})
                                begin
                                    year_mod_next = YEAR_MAX_MOD25;
                                end
                                else
                                begin
                                    year_mod_next = mod25({3'd0, year_mod_reg} * 8'd10
                                                          + {4'd0, digit});
                                end
                            end
                            else
                            begin
                                stopped_next[0] = 1'b1;
                            end
                        end
                    end
                    TOK_DOY:
                    begin
                        if (!stopped_reg[1])
                        begin
                            if (is_digit)
                            begin
                                doy_next = 10'(dec_push({4'd0, doy_reg}, digit,
                                                        {4'd0, DOY_MAX}));
                            end
                            else
                            begin
                                stopped_next[1] = 1'b1;
                            end
                        end
                    end
                    TOK_TIME:
                    begin
                        if (!stopped_reg[2])
                        begin
                            if (is_digit)
                            begin
                                time_next[part_reg] = time_pushed[6:0];
                                has_digit_next      = 1'b1;
                            end
                            else if (char_code == CHAR_COLON && has_digit_reg
                                     && part_reg < 2'd2)
                            begin
                                part_next      = part_reg + 2'd1;
                                has_digit_next = 1'b0;
                            end
                            else
                            begin
                                stopped_next[2] = 1'b1;
                            end
                        end
                    end
                    TOK_ZONE:
                    begin
                        if (zone_count_reg < 3'd4)
                        begin
                            case (zone_count_reg[1:0])
                                2'd0:    zone_next[31:24] = char_code;
                                2'd1:    zone_next[23:16] = char_code;
                                2'd2:    zone_next[15:8]  = char_code;
                                default: zone_next[7:0]   = char_code;
                            endcase
                            zone_count_next = zone_count_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_position_reg <= '0;
            inside_token_reg   <= 1'b0;
            line_nonempty_reg  <= 1'b0;
            year_reg           <= '0;
            year_mod_reg       <= '0;
            doy_reg            <= '0;
            time_reg           <= '{3{7'd0}};
            part_reg           <= '0;
            stopped_reg        <= '0;
            has_digit_reg      <= 1'b0;
            zone_reg           <= '0;
            zone_count_reg     <= '0;
        end
        else
        begin
            token_position_reg <= token_position_next;
            inside_token_reg   <= inside_token_next;
            line_nonempty_reg  <= line_nonempty_next;
            year_reg           <= year_next;
            year_mod_reg       <= year_mod_next;
            doy_reg            <= doy_next;
            time_reg           <= time_next;
            part_reg           <= part_next;
            stopped_reg        <= stopped_next;
            has_digit_reg      <= has_digit_next;
            zone_reg           <= zone_next;
            zone_count_reg     <= zone_count_next;
        end
    end

    assign state.token_position = token_position_reg;
    assign state.line_nonempty  = line_nonempty_reg;
    assign state.year           = year_reg;
    assign state.year_mod25     = year_mod_reg;
    assign state.doy            = doy_reg;
    assign state.hour           = time_reg[0];
    assign state.minute         = time_reg[1];
    assign state.second         = time_reg[2];
    assign state.zone_bytes     = zone_reg;

endmodule

// ----- rtl/atcp_date.sv -----
// day-of-year to month and day, gregorian leap years
module atcp_date import atcp_pkg::*; (
    input  logic [9:0] doy,
    input  logic [3:0] year_low,
    input  logic [4:0] year_mod25,
    output logic [3:0] month,
    output logic [4:0] day
);

    logic       leap;
    logic [9:0] end_day [12];
    logic [9:0] start_day [12];
    logic [3:0] sel;
    logic       hit;
    logic [9:0] day_wide;

    // divisible by 4 and not by 100, or divisible by 400 (16 and 25)
    assign leap = (year_low[1:0] == 2'd0 && year_mod25 != 5'd0)
               || (year_low == 4'd0 && year_mod25 == 5'd0);

    always_comb
    begin
        for (int m = 0; m < 12; m++)
        begin
            end_day[m] = {1'b0, MONTH_END[m]} + {9'd0, (m >= 1) && leap};
        end
        start_day[0] = '0;
        for (int m = 1; m < 12; m++)
        begin
            start_day[m] = end_day[m - 1];
        end

        sel = '0;
        hit = 1'b0;
        for (int m = 11; m >= 0; m--)
        begin
            if (doy <= end_day[m])
            begin
                sel = 4'(m);
                hit = 1'b1;
            end
        end

        day_wide = doy - start_day[sel];
        month    = hit ? sel + 4'd1 : 4'd0;
        day      = hit ? day_wide[4:0] : 5'd0;
    end

endmodule

// ----- rtl/ascii_time_code_line_parser.sv -----
// top level: input register, line parser, end-of-line result register
// Takes one ASCII byte per item on in_ch and sustains one item per clock. A byte is held
// in an input register until the parser takes it, then updates the token and field state; a line feed
// after a non-empty line loads the result register, where the month and day are worked out
// from day-of-year in the same cycle by a compare against the twelve month ends. A result
// is presented on out_ch straight from the result register. Input keeps flowing while
// a result waits; only a second line feed that finds the result register still full stalls.
module ascii_time_code_line_parser import atcp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    atcp_stream_if.sink   in_ch,
    atcp_stream_if.source out_ch
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;

    line_state_t state;
    logic        emit;
    logic        proceed;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        ok;
    logic        zone_here;

    assign emit    = in_valid_reg && in_char_reg == CHAR_LF && state.line_nonempty;
    assign proceed = in_valid_reg && (!emit || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_char_reg <= in_ch.data.char_code;
        end
    end

    atcp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proceed),
        .char_code (in_char_reg),
        .state     (state)
    );

    atcp_date u_date (
        .doy        (state.doy),
        .year_low   (state.year[3:0]),
        .year_mod25 (state.year_mod25),
        .month      (month),
        .day        (day)
    );

    assign ok        = state.token_position >= 4'd3;
    assign zone_here = state.token_position >= 4'd4;

    always_comb
    begin
        out_data_next              = '0;
        out_data_next.format_ok    = ok;
        out_data_next.token_total  = state.token_position;
        if (ok)
        begin
            out_data_next.year_value   = state.year;
            out_data_next.day_of_year  = state.doy;
            out_data_next.month_number = month;
            out_data_next.day_of_month = day;
            out_data_next.hour_value   = state.hour;
            out_data_next.minute_value = state.minute;
            out_data_next.second_value = state.second;
            out_data_next.zone_present = zone_here;
            out_data_next.zone_text    = zone_here ? state.zone_bytes : 32'd0;
        end

        out_valid_next = out_valid_reg;
        if (proceed && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // a line end that goes through always leaves a result behind
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        proceed && emit |=> out_valid_reg)
        else $error("line end did not load the result register");

    // a held byte is not lost or changed while the result side stalls
    a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proceed |=> in_valid_reg && $stable(in_char_reg))
        else $error("stalled byte dropped or changed");

    // a line feed clears the line state
    a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proceed && in_char_reg == CHAR_LF |=>
            state.token_position == 4'd0 && !state.line_nonempty)
        else $error("line state not cleared after line feed");

endmodule

// ----- tb/ascii_time_code_line_parser_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the time-code line parser: directed lines, then random lines
module ascii_time_code_line_parser_test;
    import atcp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 130;
    localparam int HOLD_CYCLES = 400;
    localparam int PRESSURE_LINES = 12;
    localparam int PRINT_LIMIT = 40;
    // in the directed table this byte stands for a zero byte, which a string cannot hold
    localparam logic [7:0] ZERO_STANDIN = 8'h01;
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int PHASE_IDLE [4] = '{0, 87, 0, 25};
    localparam int PHASE_STALL [4] = '{0, 0, 87, 25};
    localparam logic [7:0] ODD_CHARS [5] = '{8'h78, 8'h2D, 8'h2B, 8'hC3, CHAR_COLON};

    typedef struct {
        string   text;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    atcp_stream_if #(.payload_t(in_item_t)) in_ch ();
    atcp_stream_if #(.payload_t(result_t))  out_ch ();

    ascii_time_code_line_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    int idle_pct = 0;
    int stall_pct = 0;
    logic hold_on = 1'b0;
    int error_count = 0;
    int results_seen = 0;
    int items_sent = 0;
    int lines_sent = 0;
    int cycle_count = 0;

    result_t line_results_q [$];
    logic [7:0] line_buf [$];
    dir_row_t dir_rows [];
    bit typed_pending = 1'b0;
    result_t typed_value;

    // line parser model state, cleared by every line feed
    logic [3:0]  tok_cnt = '0;
    logic        in_tok = 1'b0;
    logic        line_used = 1'b0;
    logic [13:0] yr_acc = '0;
    logic [9:0]  doy_acc = '0;
    logic [6:0]  hms_acc [3] = '{default: '0};
    logic [1:0]  hms_sel = '0;
    logic        hms_digit = 1'b0;
    logic [2:0]  stop_bits = '0;
    logic [31:0] zone_acc = '0;
    logic [2:0]  zone_len = '0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic void split_doy(input int yr, input int doy,
                                      output logic [3:0] mo, output logic [4:0] da);
        int left;
        int span;
        left = doy;
        mo = '0;
        da = '0;
        for (int m = 0; m < 12; m++)
        begin
            span = MONTH_DAYS[m] + ((m == 1 && leap_year(yr)) ? 1 : 0);
            if (left <= span)
            begin
                mo = 4'(m + 1);
                da = 5'(left);
                return;
            end
            left -= span;
        end
    endfunction

    function automatic result_t typed_result(int ok, int tot, int yr, int doy, int mo, int da,
                                             int hh, int mm, int ss, int zp,
                                             logic [31:0] zone);
        result_t r;
        r.format_ok    = 1'(ok);
        r.token_total  = 4'(tot);
        r.year_value   = 14'(yr);
        r.day_of_year  = 10'(doy);
        r.month_number = 4'(mo);
        r.day_of_month = 5'(da);
        r.hour_value   = 7'(hh);
        r.minute_value = 7'(mm);
        r.second_value = 7'(ss);
        r.zone_present = 1'(zp);
        r.zone_text    = zone;
        return r;
    endfunction

    // advance the line model by one accepted byte; a line feed may queue a result
    task automatic parse_char(input logic [7:0] c);
        result_t r;
        logic [3:0] tok;
        bit is_digit;
        int dv;
        int v;
        if (c == CHAR_CR)
            return;
        if (c == CHAR_LF)
        begin
            if (line_used)
            begin
                r = '0;
                r.token_total = tok_cnt;
                r.format_ok = (tok_cnt >= 3);
                if (r.format_ok)
                begin
                    r.year_value = yr_acc;
                    r.day_of_year = doy_acc;
                    split_doy(yr_acc, doy_acc, r.month_number, r.day_of_month);
                    r.hour_value = hms_acc[0];
                    r.minute_value = hms_acc[1];
                    r.second_value = hms_acc[2];
                    r.zone_present = (tok_cnt >= 4);
                    r.zone_text = r.zone_present ? zone_acc : '0;
                end
                line_results_q = {line_results_q, (typed_pending ? typed_value : r)};
            end
            tok_cnt = '0;
            in_tok = 1'b0;
            line_used = 1'b0;
            yr_acc = '0;
            doy_acc = '0;
            hms_acc = '{default: '0};
            hms_sel = '0;
            hms_digit = 1'b0;
            stop_bits = '0;
            zone_acc = '0;
            zone_len = '0;
            return;
        end
        line_used = 1'b1;
        if (c == CHAR_SPACE || c == CHAR_TAB)
        begin
            in_tok = 1'b0;
            return;
        end
        if (!in_tok)
        begin
            in_tok = 1'b1;
            if (tok_cnt < TOKEN_MAX)
                tok_cnt++;
        end
        tok = tok_cnt - 4'd1;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        dv = int'(c) - int'(CHAR_ZERO);
        case (tok)
            TOK_YEAR:
                if (!stop_bits[0])
                begin
                    if (is_digit)
                    begin
                        v = int'(yr_acc) * 10 + dv;
                        yr_acc = (v > int'(YEAR_MAX)) ? YEAR_MAX : 14'(v);
                    end
                    else
                        stop_bits[0] = 1'b1;
                end
            TOK_DOY:
                if (!stop_bits[1])
                begin
                    if (is_digit)
                    begin
                        v = int'(doy_acc) * 10 + dv;
                        doy_acc = (v > int'(DOY_MAX)) ? DOY_MAX : 10'(v);
                    end
                    else
                        stop_bits[1] = 1'b1;
                end
            TOK_TIME:
                if (!stop_bits[2] && hms_sel <= 2'd2)
                begin
                    if (is_digit)
                    begin
                        v = int'(hms_acc[hms_sel]) * 10 + dv;
                        hms_acc[hms_sel] = (v > int'(TIME_MAX)) ? TIME_MAX : 7'(v);
                        hms_digit = 1'b1;
                    end
                    else if (c == CHAR_COLON && hms_digit && hms_sel < 2'd2)
                    begin
                        hms_sel++;
                        hms_digit = 1'b0;
                    end
                    else
                        stop_bits[2] = 1'b1;
                end
            TOK_ZONE:
                if (zone_len < 3'd4)
                begin
                    zone_acc |= {24'd0, c} << (8 * (3 - int'(zone_len)));
                    zone_len++;
                end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch on %s in result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (line_results_q.size() == 0)
        begin
            report_mismatch("unexpected result", got.token_total, 0);
            return;
        end
        want = line_results_q.pop_front();
        results_seen++;
        if (got.format_ok !== want.format_ok)
            report_mismatch("format_ok", got.format_ok, want.format_ok);
        if (got.token_total !== want.token_total)
            report_mismatch("token_total", got.token_total, want.token_total);
        if (got.year_value !== want.year_value)
            report_mismatch("year_value", got.year_value, want.year_value);
        if (got.day_of_year !== want.day_of_year)
            report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
        if (got.month_number !== want.month_number)
            report_mismatch("month_number", got.month_number, want.month_number);
        if (got.day_of_month !== want.day_of_month)
            report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
        if (got.hour_value !== want.hour_value)
            report_mismatch("hour_value", got.hour_value, want.hour_value);
        if (got.minute_value !== want.minute_value)
            report_mismatch("minute_value", got.minute_value, want.minute_value);
        if (got.second_value !== want.second_value)
            report_mismatch("second_value", got.second_value, want.second_value);
        if (got.zone_present !== want.zone_present)
            report_mismatch("zone_present", got.zone_present, want.zone_present);
        if (got.zone_text !== want.zone_text)
            report_mismatch("zone_text", got.zone_text, want.zone_text);
    endtask

    // receiver: random stalls plus the long hold-off, and result checking
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result(out_ch.data);
        out_ch.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ascii_time_code_line_parser_test: errors");
            $finish;
        end
    end

    task automatic hold_off(int n);
        hold_on <= 1'b1;
        repeat (n) @(posedge clk);
        hold_on <= 1'b0;
    endtask

    task automatic push_char(input logic [7:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= in_item_t'(c);
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        if (c != CHAR_CR)
            items_sent++;
        if (c == CHAR_LF)
            lines_sent++;
        parse_char(c);
    endtask

    function automatic logic [7:0] any_token_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR || b == CHAR_SPACE);
        return b;
    endfunction

    // stray carriage returns land before any byte of a line but the closing line feed
    function automatic void add_byte(logic [7:0] c);
        if ($urandom_range(29) == 0)
            line_buf = {line_buf, CHAR_CR};
        line_buf = {line_buf, c};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(8'(s[i]));
    endfunction

    function automatic void add_gap();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n) add_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    function automatic string digits_of(int v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(7) == 0)
            s = {"0", s};
        return s;
    endfunction

    function automatic int time_part();
        return ($urandom_range(9) == 0) ? $urandom_range(999) : $urandom_range(99);
    endfunction

    function automatic void build_line(bit tidy);
        int kind;
        int n;
        string t;
        line_buf.delete();
        kind = tidy ? 0 : $urandom_range(99);
        if (kind < 70)
        begin
            if ($urandom_range(9) == 0)
                add_gap();
            case ($urandom_range(5))
                0: n = $urandom_range(24) * 400;
                1: n = $urandom_range(99) * 100;
                2: n = $urandom_range(99999);
                default: n = $urandom_range(9999);
            endcase
            if ($urandom_range(19) == 0)
                add_text($urandom_range(1) ? "-" : "+");
            add_text(digits_of(n));
            add_gap();
            case ($urandom_range(5))
                0: n = $urandom_range(1) ? 0 : $urandom_range(365, 366);
                1: n = $urandom_range(59, 61);
                2: n = $urandom_range(9999);
                default: n = $urandom_range(1, 366);
            endcase
            if ($urandom_range(19) == 0)
                add_text($urandom_range(1) ? "-" : "+");
            add_text(digits_of(n));
            add_gap();
            t = {digits_of(time_part()), ":", digits_of(time_part()), ":",
                 digits_of(time_part())};
            case ($urandom_range(9))
                0: t = t.substr(0, $urandom_range(t.len() - 1));
                1: t[$urandom_range(t.len() - 1)] = ODD_CHARS[$urandom_range(4)];
                2: t = {t, ":", digits_of(time_part())};
                default: ;
            endcase
            add_text(t);
            if ($urandom_range(9) < 6)
            begin
                add_gap();
                n = $urandom_range(1, 6);
                repeat (n)
                    add_byte(($urandom_range(3) == 0) ? any_token_byte()
                                                      : 8'($urandom_range(65, 90)));
            end
            if ($urandom_range(6) == 0)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    add_gap();
                    add_text(digits_of($urandom_range(99)));
                end
            end
            if ($urandom_range(4) == 0)
                add_gap();
        end
        else if (kind < 85)
        begin
            // junk made of separators, digits, colons and any other byte
            n = $urandom_range(30);
            repeat (n)
            begin
                case ($urandom_range(5))
                    0: add_byte(CHAR_SPACE);
                    1: add_byte(CHAR_TAB);
                    2: add_byte(CHAR_ZERO + 8'($urandom_range(9)));
                    3: add_byte(CHAR_COLON);
                    default: add_byte(any_token_byte());
                endcase
            end
        end
        else if (kind < 93)
        begin
            add_text(digits_of($urandom_range(9999)));
            if ($urandom_range(1))
            begin
                add_gap();
                add_text(digits_of($urandom_range(366)));
            end
        end
        else if ($urandom_range(1))
            add_gap();
        line_buf = {line_buf, CHAR_LF};
    endfunction

    task automatic send_random_line(bit tidy);
        build_line(tidy);
        foreach (line_buf[i])
            push_char(line_buf[i]);
    endtask

    initial
    begin
        logic [7:0] c;
        int phase_start;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        dir_rows = '{
            '{"2024 366 23:59:59 UTC\015\n", 1'b1,
              typed_result(1, 4, 2024, 366, 12, 31, 23, 59, 59, 1, 32'h5554_4300)},
            '{"\n", 1'b0, '0},
            '{"\015\015\n", 1'b0, '0},
            '{" \t  \t\n", 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0)},
            '{"1 2\n", 1'b1, typed_result(0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0)},
            '{"1900 366 12:00:00\n", 1'b1,
              typed_result(1, 3, 1900, 366, 0, 0, 12, 0, 0, 0, 32'h0)},
            '{"99999 99999 999:999:999 ABCDEFG extra more\n", 1'b1,
              typed_result(1, 6, 9999, 999, 0, 0, 99, 99, 99, 1, 32'h4142_4344)},
            '{"2000 0 0:0:0\n", 1'b0, '0},
            '{"2023 60 1:2:3 Z\n", 1'b0, '0},
            '{"2024 60 00:00:00\n", 1'b0, '0},
            '{"2400 366 06:07:08\n", 1'b0, '0},
            '{"0000 001 00:00:00 UTC\n", 1'b0, '0},
            '{"9999 365 99:99:99 +0100\n", 1'b0, '0},
            '{"-5 +7 x1:2:3\n", 1'b0, '0},
            '{"2020 10 12::30 Z\n", 1'b0, '0},
            '{"2020 10 12:30:45:55x\n", 1'b0, '0},
            '{"2020 10 7a:30\n", 1'b0, '0},
            '{"2021\t200\t\t08:15:30\t\001\377\200z\n", 1'b0, '0},
            '{"a b c d e f g h i j k l m n o p q\n", 1'b0, '0},
            '{"  2019  \t 31 \015 5:6:7   \n", 1'b0, '0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            typed_pending = dir_rows[r].typed;
            typed_value = dir_rows[r].want;
            for (int i = 0; i < dir_rows[r].text.len(); i++)
            begin
                c = 8'(dir_rows[r].text[i]);
                push_char((c == ZERO_STANDIN) ? 8'h00 : c);
            end
        end
        typed_pending = 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = PHASE_IDLE[p];
            stall_pct = PHASE_STALL[p];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_line(1'b0);
        end

        // receiver blocked while full-rate lines keep coming, so the input must back up
        idle_pct = 0;
        stall_pct = 0;
        fork
            hold_off(HOLD_CYCLES);
        join_none
        repeat (PRESSURE_LINES) send_random_line(1'b1);
        in_ch.valid <= 1'b0;

        while (line_results_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d characters in %0d lines, checked %0d parsed results", items_sent,
                 lines_sent, results_seen);
        $display("idle and stall mixes: none, sender, receiver, both; one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("ascii_time_code_line_parser_test: clean");
        else
            $display("ascii_time_code_line_parser_test: errors");
        $finish;
    end

endmodule
